>>> sv/ucdcs_pkg.sv
// shared types, constants and the class decode for the configuration descriptor class scanner
// no dependencies
package ucdcs_pkg;

  localparam int unsigned OFS_W  = 16;
  localparam int unsigned MASK_W = 6;
  localparam int unsigned FILT_W = 16;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register indexes (word address bits above the byte lane)
  localparam logic REG_CLASS_FILTER = 1'b0;

  localparam logic [FILT_W-1:0] FILTER_RESET = 16'hFFFF;
  localparam logic [OFS_W-1:0]  OFFSET_MAX   = 16'hFFFF;

  localparam logic [7:0] HDR_MIN      = 8'd4;
  localparam logic [7:0] DESC_MIN     = 8'd2;
  localparam logic [7:0] IFACE_MIN    = 8'd9;
  localparam logic [7:0] MIDI_SUBCLS  = 8'd3;
  localparam logic [7:0] TYPE_IFACE   = 8'h04;

  // positions inside a descriptor
  localparam logic [OFS_W-1:0] POS_TYPE     = 16'd1;
  localparam logic [OFS_W-1:0] POS_CLASS    = 16'd5;
  localparam logic [OFS_W-1:0] POS_SUBCLASS = 16'd6;

  // header offsets
  localparam logic [OFS_W-1:0] OFS_HDR_LEN  = 16'd0;
  localparam logic [OFS_W-1:0] OFS_TOT_LO   = 16'd2;
  localparam logic [OFS_W-1:0] OFS_TOT_HI   = 16'd3;
  localparam logic [OFS_W-1:0] OFS_WALK     = 16'd4;

  localparam logic [7:0] CLS_AUDIO = 8'h01;
  localparam logic [7:0] CLS_CDC   = 8'h02;
  localparam logic [7:0] CLS_HID   = 8'h03;
  localparam logic [7:0] CLS_MSC   = 8'h08;
  localparam logic [7:0] CLS_CDATA = 8'h0A;
  localparam logic [7:0] CLS_VIDEO = 8'h0E;

  localparam logic [MASK_W-1:0] BIT_HID   = 6'h01;
  localparam logic [MASK_W-1:0] BIT_MSC   = 6'h02;
  localparam logic [MASK_W-1:0] BIT_CDC   = 6'h04;
  localparam logic [MASK_W-1:0] BIT_MIDI  = 6'h08;
  localparam logic [MASK_W-1:0] BIT_AUDIO = 6'h10;
  localparam logic [MASK_W-1:0] BIT_VIDEO = 6'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] class_mask;
    logic              filter_hit;
  } out_item_t;

  typedef struct packed {
    logic [OFS_W-1:0]  byte_offset;
    logic [OFS_W-1:0]  total_length;
    logic [OFS_W-1:0]  next_desc_start;
    logic [7:0]        desc_length;
    logic              desc_is_interface;
    logic [7:0]        class_code;
    logic              walk_stopped;
    logic [MASK_W-1:0] mask_accum;
  } walk_state_t;

  function automatic logic [MASK_W-1:0] class_bit(input logic [7:0] cls,
                                                  input logic [7:0] sub);
    logic [MASK_W-1:0] r;
    case (cls)
      CLS_HID:             r = BIT_HID;
      CLS_MSC:             r = BIT_MSC;
      CLS_CDC, CLS_CDATA:  r = BIT_CDC;
      CLS_AUDIO:           r = (sub == MIDI_SUBCLS) ? BIT_MIDI : BIT_AUDIO;
      CLS_VIDEO:           r = BIT_VIDEO;
      default:             r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/usb_config_descriptor_class_scan_core.sv
// top level of the configuration descriptor class scanner
// depends on ucdcs_pkg, ucdcs_cfg_regs and ucdcs_walk

// Scans a USB configuration descriptor block fed one byte per transaction,
// offset zero first, and on the byte flagged last_byte returns one result
// transaction: a six-bit class mask (HID, mass storage, CDC, MIDI, other
// audio, video) and filter_hit, set when the mask overlaps the class_filter
// register (APB address 0, reset 0xFFFF). Bytes that are not last produce no
// result. Each byte is caught in an input register, then a single
// combinational step updates the walk state and, for a last byte, loads
// the result register, so a new byte can be accepted every cycle while the
// input register is not stalled, and a result is offered from the result
// register. The only stall comes from the output side: a last byte waits in
// the input register while the previous result has not been taken. After a
// result the walk state returns to reset and the next byte starts a new
// block. Write class_filter only while no block is in flight.
module usb_config_descriptor_class_scan_core import ucdcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte stream
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  // result stream
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [FILT_W-1:0] class_filter;

  // input register
  logic     in_vld_q, in_vld_d;
  in_item_t in_item_q;

  // walk state
  walk_state_t state_q, state_nxt;

  // result register
  logic      out_vld_q, out_vld_d;
  out_item_t out_item_q, result;

  logic      step;      // byte in the input register is processed this cycle
  logic      out_free;  // result register can take a new result

  ucdcs_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .class_filter_o (class_filter)
  );

  ucdcs_walk u_walk (
    .cur_i          (state_q),
    .item_i         (in_item_q),
    .class_filter_i (class_filter),
    .nxt_o          (state_nxt),
    .result_o       (result)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  // only a last byte needs room in the result register
  assign step       = in_vld_q && (out_free || !in_item_q.last_byte);
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (step && in_item_q.last_byte) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step) begin
        state_q <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (step && in_item_q.last_byte) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

  // a stalled input register always holds a byte
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q)
    else $error("input stalled with empty input register");

  // a processed last byte resets the walk to offset zero
  a_block_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_item_q.last_byte) |=> (state_q.byte_offset == '0))
    else $error("walk not reset after last byte");

  // a stopped walk stays stopped until the block ends
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.walk_stopped && !(step && in_item_q.last_byte)) |=> state_q.walk_stopped)
    else $error("walk restarted inside a block");

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_item_q.last_byte) |-> (!out_vld_q || out_ready_i))
    else $error("result register overwritten");

  // the filter flag agrees with the mask and the filter register
  a_hit_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_item_q.filter_hit ==
                   (|(out_item_q.class_mask & class_filter[MASK_W-1:0]))))
    else $error("filter_hit does not match mask");

endmodule

>>> sv/ucdcs_cfg_regs.sv
// apb register file holding the class filter
// depends on ucdcs_pkg
module ucdcs_cfg_regs import ucdcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [FILT_W-1:0] class_filter_o
);

  logic [FILT_W-1:0] filter_q, filter_d;
  logic              reg_hit;

  assign reg_hit = (paddr[APB_AW-1] == REG_CLASS_FILTER);

  always_comb begin
    filter_d = filter_q;
    if (psel && penable && pwrite && reg_hit) begin
      filter_d = pwdata[FILT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= FILTER_RESET;
    end else begin
      filter_q <= filter_d;
    end
  end

  assign pready         = 1'b1;
  assign prdata         = reg_hit ? {{(APB_DW-FILT_W){1'b0}}, filter_q} : '0;
  assign class_filter_o = filter_q;

endmodule

>>> sv/ucdcs_walk.sv
// per-byte next-state and result logic of the descriptor walk
// depends on ucdcs_pkg
module ucdcs_walk import ucdcs_pkg::*; (
  input  walk_state_t       cur_i,
  input  in_item_t          item_i,
  input  logic [FILT_W-1:0] class_filter_i,
  output walk_state_t       nxt_o,
  output out_item_t         result_o
);

  logic [OFS_W-1:0] ofs;
  logic [7:0]       b;
  logic [OFS_W-1:0] start;
  logic [OFS_W-1:0] rel;
  logic [OFS_W:0]   end_min;
  logic [OFS_W:0]   end_desc;
  walk_state_t      upd;

  assign ofs      = cur_i.byte_offset;
  assign b        = item_i.data_byte;
  assign start    = cur_i.next_desc_start - {8'b0, cur_i.desc_length};
  assign rel      = ofs - start;
  assign end_min  = {1'b0, ofs} + {9'b0, DESC_MIN};
  assign end_desc = {1'b0, ofs} + {9'b0, b};

  always_comb begin
    upd = cur_i;
    if (ofs == OFS_HDR_LEN) begin
      upd.next_desc_start = {8'b0, b};
      if (b < HDR_MIN) begin
        upd.walk_stopped = 1'b1;
      end
    end else if (ofs == OFS_TOT_LO) begin
      upd.total_length[7:0] = b;
    end else if (ofs == OFS_TOT_HI) begin
      upd.total_length[15:8] = b;
    end else if (ofs >= OFS_WALK) begin
      if (!cur_i.walk_stopped && ofs < cur_i.total_length) begin
        if (ofs == cur_i.next_desc_start) begin
          // descriptor start: check it fits in the total
          if (end_min > {1'b0, cur_i.total_length} || b < DESC_MIN ||
              end_desc > {1'b0, cur_i.total_length}) begin
            upd.walk_stopped = 1'b1;
          end else begin
            upd.desc_length       = b;
            upd.next_desc_start   = end_desc[OFS_W-1:0];
            upd.desc_is_interface = 1'b0;
            upd.class_code        = '0;
          end
        end else if (cur_i.desc_length != 8'd0 && ofs >= start) begin
          case (rel)
            POS_TYPE: begin
              upd.desc_is_interface = (b == TYPE_IFACE) && (cur_i.desc_length >= IFACE_MIN);
            end
            POS_CLASS: begin
              upd.class_code = b;
            end
            POS_SUBCLASS: begin
              if (cur_i.desc_is_interface) begin
                upd.mask_accum = cur_i.mask_accum | class_bit(cur_i.class_code, b);
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    if (cur_i.byte_offset != OFFSET_MAX) begin
      upd.byte_offset = cur_i.byte_offset + 16'd1;
    end
  end

  assign result_o.class_mask = upd.mask_accum;
  assign result_o.filter_hit = |(upd.mask_accum & class_filter_i[MASK_W-1:0]);
  assign nxt_o               = item_i.last_byte ? '0 : upd;

endmodule
